/* sv/box_intersection_over_union_assert.svh */
// Assertion macros for the box intersection-over-union checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BOX_INTERSECTION_OVER_UNION_ASSERT_SVH
`define BOX_INTERSECTION_OVER_UNION_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BIOU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("biou check failed");

// Check a property on every clock edge, reset included.
`define BIOU_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("biou reset check failed");

`endif

/* sv/biou_pkg.sv */
// Shared constants and packing helpers for the box intersection-over-union block.
// No dependencies; used by the top level and the port checker.
package biou_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Bits of the result beat that carry fields, lowest field first.
    function automatic int out_used(input int cw, input int fb);
        return 12 * cw + fb + 3;
    endfunction

    // Result beat width, padded to whole bytes.
    function automatic int out_bits(input int cw, input int fb);
        return ((out_used(cw, fb) + 7) / 8) * 8;
    endfunction

endpackage

/* sv/box_intersection_over_union.sv */
// Box intersection over union: top level with the geometry and area stages.
// Depends on biou_pkg and biou_frac_div.
//
// Takes one pair of axis-aligned boxes per beat and returns one result beat per pair:
// both areas, the overlap flag, the intersection box and area, the union area and the
// ratio cut_area / union_area as truncated unsigned Q1.FRAC_BITS (2^FRAC_BITS is 1.0).
// Boxes that only touch overlap with zero cut area. A box with left >= right or
// bottom >= top sets tuser (bad box) and zeroes every tdata field; with no overlap the
// cut fields, union and ratio are zero while both areas stand. The block accepts a new
// beat every cycle while the master side does not stall. The pipeline has four
// stages for compare, width multiply, cut multiply and union, then FRAC_BITS + 1
// divider stages, one quotient bit each, the last of which is the output register.
// Stalls on the master side back up stage by stage; empty stages keep filling, so
// no beat is lost or repeated. The block has no configuration and no state.
module box_intersection_over_union #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // fields from bit 0 up: a_left, a_bottom, a_right, a_top,
    // b_left, b_bottom, b_right, b_top (COORD_BITS each, signed)
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [8*COORD_BITS-1:0] s_axis_tdata,
    // fields from bit 0 up: area_a, area_b, overlap, cut_left, cut_bottom, cut_right,
    // cut_top, cut_area, union_area, ratio_q16, then zero fill
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [biou_pkg::out_bits(COORD_BITS, FRAC_BITS)-1:0] m_axis_tdata,
    // fields from bit 0 up: bad_box
    output logic                    m_axis_tuser
);

    localparam int CW        = COORD_BITS;
    localparam int AW        = 2 * COORD_BITS;
    localparam int UW        = 2 * COORD_BITS + 1;
    localparam int USED      = biou_pkg::out_used(COORD_BITS, FRAC_BITS);
    localparam int SIDE_BITS = 12 * COORD_BITS + 3;

    // Unpack the input beat.
    logic signed [CW-1:0] w_al, w_ab, w_ar, w_at, w_bl, w_bb, w_br, w_bt;
    assign w_al = s_axis_tdata[0*CW +: CW];
    assign w_ab = s_axis_tdata[1*CW +: CW];
    assign w_ar = s_axis_tdata[2*CW +: CW];
    assign w_at = s_axis_tdata[3*CW +: CW];
    assign w_bl = s_axis_tdata[4*CW +: CW];
    assign w_bb = s_axis_tdata[5*CW +: CW];
    assign w_br = s_axis_tdata[6*CW +: CW];
    assign w_bt = s_axis_tdata[7*CW +: CW];

    // Stage handshake: a stage loads when empty or when its beat moves on.
    logic w_adv1, w_adv2, w_adv3, w_adv4, w_div_ready;
    logic r1_vld, r2_vld, r3_vld, r4_vld;

    assign w_adv4        = !r4_vld || w_div_ready;
    assign w_adv3        = !r3_vld || w_adv4;
    assign w_adv2        = !r2_vld || w_adv3;
    assign w_adv1        = !r1_vld || w_adv2;
    assign s_axis_tready = w_adv1;

    // ---------------- Stage 1: corner checks, overlap, cut corners, box sides
    logic                 n1_bad, n1_ov;
    logic signed [CW-1:0] n1_cl, n1_cb, n1_cr, n1_ct;
    logic        [CW-1:0] n1_aw, n1_ah, n1_bw, n1_bh;

    always_comb begin
        n1_bad = (w_al >= w_ar) || (w_ab >= w_at) || (w_bl >= w_br) || (w_bb >= w_bt);
        n1_ov  = !((w_ar < w_bl) || (w_at < w_bb) || (w_al > w_br) || (w_ab > w_bt));
        n1_cl  = (w_al > w_bl) ? w_al : w_bl;
        n1_cb  = (w_ab > w_bb) ? w_ab : w_bb;
        n1_cr  = (w_ar < w_br) ? w_ar : w_br;
        n1_ct  = (w_at < w_bt) ? w_at : w_bt;
        // Sides are positive for good boxes and fit CW bits unsigned.
        n1_aw  = CW'($unsigned(w_ar - w_al));
        n1_ah  = CW'($unsigned(w_at - w_ab));
        n1_bw  = CW'($unsigned(w_br - w_bl));
        n1_bh  = CW'($unsigned(w_bt - w_bb));
    end

    logic                 r1_bad, r1_ov;
    logic signed [CW-1:0] r1_cl, r1_cb, r1_cr, r1_ct;
    logic        [CW-1:0] r1_aw, r1_ah, r1_bw, r1_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_adv1) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_bad <= n1_bad;
            r1_ov  <= n1_ov;
            r1_cl  <= n1_cl;
            r1_cb  <= n1_cb;
            r1_cr  <= n1_cr;
            r1_ct  <= n1_ct;
            r1_aw  <= n1_aw;
            r1_ah  <= n1_ah;
            r1_bw  <= n1_bw;
            r1_bh  <= n1_bh;
        end
    end

    // ---------------- Stage 2: box areas, cut sides
    logic [AW-1:0] n2_area_a, n2_area_b;
    logic [CW-1:0] n2_cw, n2_ch;

    assign n2_area_a = AW'(r1_aw) * AW'(r1_ah);
    assign n2_area_b = AW'(r1_bw) * AW'(r1_bh);
    // Only meaningful when the boxes overlap; zeroed later otherwise.
    assign n2_cw     = CW'($unsigned(r1_cr - r1_cl));
    assign n2_ch     = CW'($unsigned(r1_ct - r1_cb));

    logic                 r2_bad, r2_ov;
    logic signed [CW-1:0] r2_cl, r2_cb, r2_cr, r2_ct;
    logic        [AW-1:0] r2_area_a, r2_area_b;
    logic        [CW-1:0] r2_cw, r2_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_adv2) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_bad    <= r1_bad;
            r2_ov     <= r1_ov;
            r2_cl     <= r1_cl;
            r2_cb     <= r1_cb;
            r2_cr     <= r1_cr;
            r2_ct     <= r1_ct;
            r2_area_a <= n2_area_a;
            r2_area_b <= n2_area_b;
            r2_cw     <= n2_cw;
            r2_ch     <= n2_ch;
        end
    end

    // ---------------- Stage 3: cut area
    logic [AW-1:0] n3_cut;
    assign n3_cut = AW'(r2_cw) * AW'(r2_ch);

    logic                 r3_bad, r3_ov;
    logic signed [CW-1:0] r3_cl, r3_cb, r3_cr, r3_ct;
    logic        [AW-1:0] r3_area_a, r3_area_b, r3_cut;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_adv3) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r3_bad    <= r2_bad;
            r3_ov     <= r2_ov;
            r3_cl     <= r2_cl;
            r3_cb     <= r2_cb;
            r3_cr     <= r2_cr;
            r3_ct     <= r2_ct;
            r3_area_a <= r2_area_a;
            r3_area_b <= r2_area_b;
            r3_cut    <= n3_cut;
        end
    end

    // ---------------- Stage 4: union, zeroing of the special cases, divider operands
    logic          w4_keep_a, w4_keep_c;
    logic [UW-1:0] w4_union;

    assign w4_keep_a = !r3_bad;
    assign w4_keep_c = !r3_bad && r3_ov;
    assign w4_union  = UW'(r3_area_a) + UW'(r3_area_b) - UW'(r3_cut);

    logic                 r4_bad, r4_ov;
    logic        [CW-1:0] r4_cl, r4_cb, r4_cr, r4_ct;
    logic        [AW-1:0] r4_area_a, r4_area_b, r4_cut;
    logic        [UW-1:0] r4_union, r4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_adv4) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv4) begin
            r4_bad    <= r3_bad;
            r4_ov     <= w4_keep_c;
            r4_area_a <= w4_keep_a ? r3_area_a : '0;
            r4_area_b <= w4_keep_a ? r3_area_b : '0;
            r4_cl     <= w4_keep_c ? r3_cl : '0;
            r4_cb     <= w4_keep_c ? r3_cb : '0;
            r4_cr     <= w4_keep_c ? r3_cr : '0;
            r4_ct     <= w4_keep_c ? r3_ct : '0;
            r4_cut    <= w4_keep_c ? r3_cut : '0;
            r4_union  <= w4_keep_c ? w4_union : '0;
            // Divide zero by one where the ratio must read zero.
            r4_den    <= w4_keep_c ? w4_union : UW'(1);
        end
    end

    // ---------------- Divider stages; the last one drives the master side
    logic [SIDE_BITS-1:0] w_side_in, w_side_out;
    logic [FRAC_BITS:0]   w_ratio;

    assign w_side_in = {r4_bad, r4_union, r4_cut, r4_ct, r4_cr, r4_cb, r4_cl, r4_ov,
                        r4_area_b, r4_area_a};

    biou_frac_div #(
        .NUM_BITS  (AW),
        .DEN_BITS  (UW),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_BITS (SIDE_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r4_vld),
        .o_in_ready  (w_div_ready),
        .i_num       (r4_cut),
        .i_den       (r4_den),
        .i_side      (w_side_in),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_quo       (w_ratio),
        .o_side      (w_side_out)
    );

    // Pack the result beat: sideband fields below the ratio, bad box to tuser.
    always_comb begin
        m_axis_tdata             = '0;
        m_axis_tdata[USED-1:0]   = {w_ratio, w_side_out[SIDE_BITS-2:0]};
    end
    assign m_axis_tuser = w_side_out[SIDE_BITS-1];

endmodule

/* sv/biou_frac_div.sv */
// Pipelined restoring divider: one quotient bit per stage, floor(num * 2^FRAC_BITS / den).
// Requires num <= den and den != 0; carries a sideband word alongside. No package use.
module biou_frac_div #(
    parameter int NUM_BITS  = 32,
    parameter int DEN_BITS  = 33,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FRAC_BITS:0]   o_quo,
    output logic [SIDE_BITS-1:0] o_side
);

    localparam int LAST = FRAC_BITS;

    logic                 r_vld  [LAST+1];
    logic                 w_adv  [LAST+1];
    logic [FRAC_BITS:0]   r_quo  [LAST+1];
    logic [DEN_BITS-1:0]  r_rem  [LAST+1];
    logic [DEN_BITS-1:0]  r_den  [LAST+1];
    logic [SIDE_BITS-1:0] r_side [LAST+1];

    for (genvar k = 0; k <= LAST; k++) begin : g_stage
        logic                 w_src_vld;
        logic [DEN_BITS-1:0]  w_src_den;
        logic [SIDE_BITS-1:0] w_src_side;
        logic [DEN_BITS-1:0]  n_rem;
        logic [FRAC_BITS:0]   n_quo;

        // A stage takes a beat when it is empty or its own beat moves on.
        if (k == LAST) begin : g_tail
            assign w_adv[k] = !r_vld[k] || i_out_ready;
        end else begin : g_body
            assign w_adv[k] = !r_vld[k] || w_adv[k+1];
        end

        if (k == 0) begin : g_first
            logic [DEN_BITS-1:0] w_num;
            logic                w_ge;
            assign w_num      = DEN_BITS'(i_num);
            assign w_ge       = (w_num >= i_den);
            assign w_src_vld  = i_in_valid;
            assign w_src_den  = i_den;
            assign w_src_side = i_side;
            assign n_rem      = w_ge ? (w_num - i_den) : w_num;
            assign n_quo      = (FRAC_BITS + 1)'(w_ge);
        end else begin : g_next
            logic [DEN_BITS:0] w_sh;
            logic [DEN_BITS:0] w_dn;
            logic              w_ge;
            assign w_sh       = {r_rem[k-1], 1'b0};
            assign w_dn       = {1'b0, r_den[k-1]};
            assign w_ge       = (w_sh >= w_dn);
            assign w_src_vld  = r_vld[k-1];
            assign w_src_den  = r_den[k-1];
            assign w_src_side = r_side[k-1];
            assign n_rem      = w_ge ? DEN_BITS'(w_sh - w_dn) : w_sh[DEN_BITS-1:0];
            assign n_quo      = {r_quo[k-1][FRAC_BITS-1:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_vld[k] <= w_src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k]) begin
                r_quo[k]  <= n_quo;
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_src_den;
                r_side[k] <= w_src_side;
            end
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_vld[LAST];
    assign o_quo       = r_quo[LAST];
    assign o_side      = r_side[LAST];

endmodule

/* sv/biou_check.sv */
// Port checker for the box intersection-over-union block, attached by bind.
// Depends on biou_pkg and box_intersection_over_union_assert.svh.
`include "box_intersection_over_union_assert.svh"

module biou_check #(
    parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [8*COORD_BITS-1:0] s_axis_tdata,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [biou_pkg::out_bits(COORD_BITS, FRAC_BITS)-1:0] m_axis_tdata,
    input logic                    m_axis_tuser
);

    localparam int USED   = biou_pkg::out_used(COORD_BITS, FRAC_BITS);
    localparam int OV_BIT = 4 * COORD_BITS;
    localparam int RQ_LSB = USED - FRAC_BITS - 1;

    logic w_out_stall;
    logic w_ov;
    logic [FRAC_BITS:0] w_ratio;
    logic [USED-OV_BIT-2:0] w_cut_fields;

    assign w_out_stall  = m_axis_tvalid && !m_axis_tready;
    assign w_ov         = m_axis_tdata[OV_BIT];
    assign w_ratio      = m_axis_tdata[USED-1:RQ_LSB];
    assign w_cut_fields = m_axis_tdata[USED-1:OV_BIT+1];

    // Hold a stalled result beat.
    `BIOU_ASSERT(a_out_hold, w_out_stall |=> m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))

    // A bad box clears every data field.
    `BIOU_ASSERT(a_bad_clear, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)

    // Without overlap the cut fields, union and ratio read zero.
    `BIOU_ASSERT(a_no_ov_clear, m_axis_tvalid && !w_ov |-> w_cut_fields == '0)

    // The ratio never exceeds one.
    `BIOU_ASSERT(a_ratio_max, m_axis_tvalid |-> w_ratio <= ((FRAC_BITS+1)'(1) << FRAC_BITS))

    // Reset empties the pipeline, so no beat shows in the cycle after it.
    `BIOU_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind box_intersection_over_union biou_check #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_biou_check (.*);

/* tb/sv/tb.sv */
// Self-checking bench for box_intersection_over_union: drives box pairs, predicts every
// result beat in SystemVerilog and compares it field by field. Depends on biou_pkg and
// on the RTL of the block; needs no files or arguments.
module tb;

    localparam int COORD_W   = biou_pkg::COORD_BITS_DEF;
    localparam int FRAC_W    = biou_pkg::FRAC_BITS_DEF;
    localparam int RESULT_W  = biou_pkg::out_bits(COORD_W, FRAC_W);
    localparam int RANDOM_PAIRS = 1550;
    // Idle time after the last match, with margin, so that the pipeline can empty.
    localparam int DRAIN_CYCLES = 2 * (FRAC_W + 5);
    localparam longint CYCLE_LIMIT = 1_000_000;

    // Packed so that a_left lands in bit 0 of tdata: last member is lowest.
    typedef struct packed {
        logic signed [15:0] b_top;
        logic signed [15:0] b_right;
        logic signed [15:0] b_bottom;
        logic signed [15:0] b_left;
        logic signed [15:0] a_top;
        logic signed [15:0] a_right;
        logic signed [15:0] a_bottom;
        logic signed [15:0] a_left;
    } box_pair_t;

    // Result tdata, lowest field last; the top bits are byte fill.
    typedef struct packed {
        logic [4:0]         fill;
        logic [16:0]        ratio_q16;
        logic [32:0]        union_area;
        logic [31:0]        cut_area;
        logic signed [15:0] cut_top;
        logic signed [15:0] cut_right;
        logic signed [15:0] cut_bottom;
        logic signed [15:0] cut_left;
        logic               overlap;
        logic [31:0]        area_b;
        logic [31:0]        area_a;
    } iou_fields_t;

    typedef struct packed {
        logic        bad_box;
        iou_fields_t data;
    } iou_beat_t;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [8*COORD_W-1:0] s_axis_tdata = '0;  // a_left, a_bottom, a_right, a_top,
                                              // b_left, b_bottom, b_right, b_top
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [RESULT_W-1:0] m_axis_tdata;        // area_a, area_b, overlap, cut_left,
                                              // cut_bottom, cut_right, cut_top,
                                              // cut_area, union_area, ratio_q16
    logic                m_axis_tuser;        // bad_box

    box_pair_t box_pairs_to_send[$];
    iou_beat_t expected_ious[$];

    bit     mismatch_seen = 1'b0;
    int     send_gap = 0;
    int     sink_stall = 0;
    bit     send_steady = 1'b0;
    bit     sink_steady = 1'b0;
    longint cycle_count = 0;

    box_intersection_over_union #(
        .COORD_BITS(COORD_W),
        .FRAC_BITS (FRAC_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected beat for one box pair. Widths are wide enough that no product or sum
    // wraps, so plain 64-bit arithmetic matches the block exactly.
    function automatic iou_beat_t predict_iou(input box_pair_t p);
        longint al, ab, ar, at, bl, bb, br, bt;
        longint cl, cb, cr, ct;
        longint area_a, area_b, cut, uni;
        iou_beat_t r;
        al = p.a_left;   ab = p.a_bottom; ar = p.a_right; at = p.a_top;
        bl = p.b_left;   bb = p.b_bottom; br = p.b_right; bt = p.b_top;
        r = '0;
        // Inverted or empty box: flag only, every data field stays zero.
        if (al >= ar || ab >= at || bl >= br || bb >= bt) begin
            r.bad_box = 1'b1;
            return r;
        end
        area_a = (ar - al) * (at - ab);
        area_b = (br - bl) * (bt - bb);
        r.data.area_a = 32'(area_a);
        r.data.area_b = 32'(area_b);
        // Apart on either axis: only the two areas stand.
        if (ar < bl || at < bb || al > br || ab > bt)
            return r;
        cl = (al > bl) ? al : bl;
        cb = (ab > bb) ? ab : bb;
        cr = (ar < br) ? ar : br;
        ct = (at < bt) ? at : bt;
        cut = (cr - cl) * (ct - cb);
        uni = area_a + area_b - cut;
        r.data.overlap    = 1'b1;
        r.data.cut_left   = 16'(cl);
        r.data.cut_bottom = 16'(cb);
        r.data.cut_right  = 16'(cr);
        r.data.cut_top    = 16'(ct);
        r.data.cut_area   = 32'(cut);
        r.data.union_area = 33'(uni);
        r.data.ratio_q16  = (uni == 0) ? '0 : 17'((cut << FRAC_W) / uni);
        return r;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int draw_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_pair(input int al, input int ab, input int ar, input int at,
                            input int bl, input int bb, input int br, input int bt);
        box_pair_t p;
        p.a_left = 16'(al);  p.a_bottom = 16'(ab);
        p.a_right = 16'(ar); p.a_top = 16'(at);
        p.b_left = 16'(bl);  p.b_bottom = 16'(bb);
        p.b_right = 16'(br); p.b_top = 16'(bt);
        box_pairs_to_send.push_back(p);
    endtask

    // Span near a center; reach sets both the jitter and the size.
    task automatic near_span(input int center, input int reach, output int lo, output int hi);
        lo = center - reach / 2 + $urandom_range(0, reach);
        hi = lo + 1 + $urandom_range(0, reach);
    endtask

    // Span anywhere in the coordinate range.
    task automatic wide_span(output int lo, output int hi);
        int x, y;
        do begin
            x = int'($signed(16'($urandom())));
            y = int'($signed(16'($urandom())));
        end while (x == y);
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
    endtask

    task automatic add_random_pair();
        int al, ab, ar, at, bl, bb, br, bt;
        int kind, reach, cx, cy, w, tmp;
        kind = $urandom_range(0, 99);
        // Raw bits: nearly always a bad box, reaches every sign and bit pattern.
        if (kind < 5) begin
            box_pairs_to_send.push_back(box_pair_t'({$urandom(), $urandom(),
                                                     $urandom(), $urandom()}));
            return;
        end
        if (kind < 15) begin
            wide_span(al, ar); wide_span(ab, at);
            wide_span(bl, br); wide_span(bb, bt);
        end else begin
            // Both boxes around one center, so overlap is common.
            case ($urandom_range(0, 2))
                0: reach = 3;
                1: reach = 40;
                default: reach = 600;
            endcase
            cx = $urandom_range(0, 62000) - 31000;
            cy = $urandom_range(0, 62000) - 31000;
            near_span(cx, reach, al, ar); near_span(cy, reach, ab, at);
            near_span(cx, reach, bl, br); near_span(cy, reach, bb, bt);
            // Slide B so that it just touches A along an edge.
            if (kind < 22) begin
                if ($urandom_range(0, 1)) begin
                    w = br - bl; bl = ar; br = ar + w;
                end else begin
                    w = at - ab; bt = ab; bb = ab - w;
                end
            end
            // Break one box: empty or inverted on one axis.
            if (kind >= 90) begin
                case ($urandom_range(0, 7))
                    0: ar = al;
                    1: begin tmp = al; al = ar; ar = tmp; end
                    2: at = ab;
                    3: begin tmp = ab; ab = at; at = tmp; end
                    4: br = bl;
                    5: begin tmp = bl; bl = br; br = tmp; end
                    6: bt = bb;
                    default: begin tmp = bb; bb = bt; bt = tmp; end
                endcase
            end
        end
        add_pair(al, ab, ar, at, bl, bb, br, bt);
    endtask

    task automatic compare_field(input string name, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    // Source side: hold each beat until accepted, then predict it and advance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_ious.push_back(predict_iou(box_pairs_to_send.pop_front()));
                if ($urandom_range(0, 79) == 0)
                    send_steady = !send_steady;
                send_gap = draw_gap(send_steady);
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (box_pairs_to_send.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= box_pairs_to_send[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: stall at random, check each accepted beat against the oldest prediction.
    always @(posedge i_clk) begin
        iou_beat_t want;
        iou_beat_t got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.bad_box = m_axis_tuser;
                got.data    = iou_fields_t'(m_axis_tdata);
                if (expected_ious.size() == 0) begin
                    $error("result beat with no box pair outstanding");
                    mismatch_seen = 1'b1;
                end else begin
                    want = expected_ious.pop_front();
                    compare_field("bad_box",    want.bad_box,         got.bad_box);
                    compare_field("area_a",     want.data.area_a,     got.data.area_a);
                    compare_field("area_b",     want.data.area_b,     got.data.area_b);
                    compare_field("overlap",    want.data.overlap,    got.data.overlap);
                    compare_field("cut_left",   want.data.cut_left,   got.data.cut_left);
                    compare_field("cut_bottom", want.data.cut_bottom, got.data.cut_bottom);
                    compare_field("cut_right",  want.data.cut_right,  got.data.cut_right);
                    compare_field("cut_top",    want.data.cut_top,    got.data.cut_top);
                    compare_field("cut_area",   want.data.cut_area,   got.data.cut_area);
                    compare_field("union_area", want.data.union_area, got.data.union_area);
                    compare_field("ratio_q16",  want.data.ratio_q16,  got.data.ratio_q16);
                    compare_field("fill",       want.data.fill,       got.data.fill);
                end
            end
            if ($urandom_range(0, 149) == 0)
                sink_steady = !sink_steady;
            if (sink_stall > 0) begin
                sink_stall = sink_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                sink_stall = draw_gap(sink_steady);
                m_axis_tready <= (sink_stall == 0);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // Directed pairs: coordinate extremes, touching, apart, and bad boxes.
        add_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
        add_pair(0, 0, 1, 1, 0, 0, 1, 1);
        add_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1);
        add_pair(0, 0, 10, 10, 5, 5, 15, 15);
        add_pair(0, 0, 1000, 1000, 0, 0, 1000, 999);
        add_pair(0, 0, 10, 10, 10, 0, 20, 10);          // touch on an edge
        add_pair(0, 0, 10, 10, 10, 10, 20, 20);         // touch at a corner
        add_pair(0, 0, 10, 10, 11, 0, 20, 10);          // B to the right
        add_pair(0, 0, 10, 10, 0, 11, 10, 20);          // B above
        add_pair(20, 20, 30, 30, 0, 20, 19, 30);        // B to the left
        add_pair(20, 20, 30, 30, 20, 0, 30, 19);        // B below
        add_pair(-32768, -32768, -32767, -32767, 32766, 32766, 32767, 32767);
        add_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        add_pair(-32768, -32768, 32767, 0, -32768, 0, 32767, 32767);
        add_pair(-100, -50, -10, -5, -60, -80, 20, -20);
        add_pair(-5, -5, 5, 5, -500, -500, 500, 500);   // B contains A
        add_pair(3, 0, 3, 10, 0, 0, 10, 10);            // A empty in x
        add_pair(32767, 0, -32768, 10, 0, 0, 10, 10);   // A inverted in x
        add_pair(0, 10, 10, 0, 0, 0, 10, 10);           // A inverted in y
        add_pair(0, 0, 10, 10, 10, 0, 0, 10);           // B inverted in x
        add_pair(0, 0, 10, 10, 0, 7, 10, 7);            // B empty in y
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        repeat (RANDOM_PAIRS)
            add_random_pair();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent and every prediction matched, then let the pipe empty.
        while (box_pairs_to_send.size() != 0 || expected_ious.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!mismatch_seen)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/biou_pkg.sv
sv/biou_frac_div.sv
sv/box_intersection_over_union.sv
sv/biou_check.sv
tb/sv/tb.sv
